// ----- src/wbss_pkg.sv -----
// Package for the wildcard byte signature scanner.
// Holds configuration types, register indexes and a shared helper function.
// No dependencies.
package wbss_pkg;

   // Window depth used when the top level is not overridden.
   localparam int DEFAULT_PATTERN_BYTES = 32;

   // Shortest pattern that still covers a 32-bit word.
   localparam int MIN_PATTERN_BYTES = 4;

   // Number of pattern bytes held in the configuration registers.
   localparam int PATTERN_REG_BYTES = 32;
   localparam int PATTERN_BITS = PATTERN_REG_BYTES * 8;

   // Register port geometry: 64-bit data, registers at 8-byte steps.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_INDEX_W = 3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RELATIVE    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE        = 3'd7;

   // Reset value of the pattern length register.
   localparam logic [5:0] PATTERN_LEN_RESET = 6'd4;

   // A pattern byte of this value matches any image byte.
   localparam logic [7:0] WILDCARD_BYTE = 8'h00;

   // Configuration as seen by the scan logic.
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [5:0]              pattern_length;
      logic [31:0]             extra_offset;
      logic                    relative_mode;
      logic [31:0]             image_base;
   } cfg_type;

   // One result handed from the scan logic to the output pipe.
   typedef struct packed {
      logic        found;
      logic [31:0] word;
   } result_type;

   // Pattern byte at a given position; positions past the register file are wildcards.
   function automatic logic [7:0] pattern_byte(logic [PATTERN_BITS-1:0] pat,
                                               logic [7:0] idx);
      logic [7:0] sel;
      sel = WILDCARD_BYTE;
      if (idx < 8'(PATTERN_REG_BYTES)) begin
         sel = pat[{idx[4:0], 3'b000} +: 8];
      end
      return sel;
   endfunction

endpackage

// ----- src/wildcard_byte_signature_scanner.sv -----
// Wildcard byte signature scanner: one image byte per cycle while req_stall is low; the
// byte window, a row of cells that shifts once per item, sets the throughput.
// A result moves from the holding stage into the output register, which drives rsp_valid;
// the holding stage keeps it while rsp_stall holds the output register full.
// The input stalls only while rsp_stall holds both result stages full.
// Synchronous reset clears the scan state, the result pipe and the registers, but not the
// window bytes, since only bytes of the current image are compared.
module wildcard_byte_signature_scanner #(
   parameter int PATTERN_BYTES = wbss_pkg::DEFAULT_PATTERN_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [31:0]                       rsp_value,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wbss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [wbss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [wbss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
   localparam int IDX_W = $clog2(PATTERN_BYTES);

   wbss_pkg::cfg_type    cfg;
   wbss_pkg::result_type push_result;

   logic [LEN_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic             match_done_ff, match_done_in;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] seen_inc;
   logic [7:0]       plen_wide;
   logic [7:0]       shift_byte [PATTERN_BYTES];
   logic [7:0]       window_byte [PATTERN_BYTES];
   logic [PATTERN_BYTES-1:0] cell_hit;
   logic             full;
   logic             accept;
   logic             scan;
   logic             seen_ok;
   logic             found;
   logic             push;
   logic [IDX_W-1:0] word_idx [4];

   // Register file.
   wbss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Clamp the configured length into the window.
   assign plen_wide = {2'b00, cfg.pattern_length};
   always_comb begin
      if (plen_wide < 8'(wbss_pkg::MIN_PATTERN_BYTES)) begin
         eff_len = LEN_W'(wbss_pkg::MIN_PATTERN_BYTES);
      end else if (plen_wide > 8'(PATTERN_BYTES)) begin
         eff_len = LEN_W'(PATTERN_BYTES);
      end else begin
         eff_len = LEN_W'(plen_wide);
      end
   end

   // Handshake and scan qualifiers.
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign scan      = accept && !match_done_ff;

   // Row of window cells; cell zero takes the newest byte.
   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
      logic             used;
      logic [LEN_W-1:0] pidx;
      logic [7:0]       pat_byte;

      // The oldest byte of the match lines up with pattern byte zero.
      assign used     = LEN_W'(j) < eff_len;
      assign pidx     = eff_len - LEN_W'(j) - LEN_W'(1);
      assign pat_byte = used ? wbss_pkg::pattern_byte(cfg.pattern, 8'(pidx))
                             : wbss_pkg::WILDCARD_BYTE;

      if (j == 0) begin : g_head
         assign shift_byte[j] = req_data_byte;
      end else begin : g_body
         assign shift_byte[j] = window_byte[j-1];
      end

      wbss_cell u_cell (
         .clock       (clock),
         .shift_en    (scan),
         .shift_byte  (shift_byte[j]),
         .pat_byte    (pat_byte),
         .window_byte (window_byte[j]),
         .hit         (cell_hit[j])
      );
   end

   // Saturating count of bytes taken in the current image.
   assign seen_inc = (bytes_seen_ff < LEN_W'(PATTERN_BYTES)) ? bytes_seen_ff + LEN_W'(1)
                                                             : bytes_seen_ff;
   assign seen_ok  = seen_inc >= eff_len;
   assign found    = scan && seen_ok && (&cell_hit);
   assign push     = scan && (found || req_is_last);

   // Word at the match start, little endian, taken from the bytes entering the cells.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         word_idx[k] = IDX_W'(eff_len - LEN_W'(k + 1));
      end
   end

   always_comb begin
      push_result.found = found;
      push_result.word  = '0;
      if (found) begin
         push_result.word = {shift_byte[word_idx[3]], shift_byte[word_idx[2]],
                             shift_byte[word_idx[1]], shift_byte[word_idx[0]]};
      end
   end

   // Scan state; the last byte of an image starts the next one afresh.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      match_done_in = match_done_ff;
      if (accept && req_is_last) begin
         bytes_seen_in = '0;
         match_done_in = 1'b0;
      end else if (scan) begin
         bytes_seen_in = seen_inc;
         match_done_in = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         match_done_ff <= match_done_in;
      end
   end

   // Result pipe.
   wbss_result u_result (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_result (push_result),
      .cfg         (cfg),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_found   (rsp_found),
      .rsp_value   (rsp_value)
   );

   // A match that is not on the last byte silences the rest of the image.
   a_match_latches: assert property (@(posedge clock) disable iff (reset)
      found && !req_is_last |=> match_done_ff)
      else $error("match did not set the done flag");

   // Once matched, no further result is produced for the image.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      match_done_ff |-> !found)
      else $error("second match in one image");

   // The byte count never runs past the window depth.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= LEN_W'(PATTERN_BYTES))
      else $error("byte count beyond window depth");

endmodule

// ----- src/wbss_cell.sv -----
// One cell of the sliding byte window of the signature scanner.
// Holds one image byte and compares the byte shifting in against its pattern byte.
// Depends on wbss_pkg.
module wbss_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] shift_byte,
   input  logic [7:0] pat_byte,
   output logic [7:0] window_byte,
   output logic       hit
);

   logic [7:0] window_byte_ff;
   logic [7:0] window_byte_in;

   // The byte moves one cell further from the input on every scanned item.
   assign window_byte_in = shift_en ? shift_byte : window_byte_ff;

   always_ff @(posedge clock) begin
      window_byte_ff <= window_byte_in;
   end

   assign window_byte = window_byte_ff;

   // A wildcard matches anything; otherwise the incoming byte must be equal.
   assign hit = (pat_byte == wbss_pkg::WILDCARD_BYTE) || (pat_byte == shift_byte);

endmodule

// ----- src/wbss_csr.sv -----
// Configuration registers of the signature scanner behind a simple APB-style port.
// Presents the register contents as one configuration struct.
// Depends on wbss_pkg.
module wbss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wbss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [wbss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [wbss_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output wbss_pkg::cfg_type                   cfg
);

   logic [wbss_pkg::CSR_DATA_W-1:0] pattern_ff [4];
   logic [wbss_pkg::CSR_DATA_W-1:0] pattern_in [4];
   logic [5:0]                      pattern_length_ff, pattern_length_in;
   logic [31:0]                     extra_offset_ff, extra_offset_in;
   logic                            relative_mode_ff, relative_mode_in;
   logic [31:0]                     image_base_ff, image_base_in;
   logic [wbss_pkg::CSR_INDEX_W-1:0] reg_index;
   logic                            write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[wbss_pkg::CSR_ADDR_W-1:3];
   assign write_en  = psel && penable && pwrite && pready;

   // Write decode.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pattern_in[k] = pattern_ff[k];
      end
      pattern_length_in = pattern_length_ff;
      extra_offset_in   = extra_offset_ff;
      relative_mode_in  = relative_mode_ff;
      image_base_in     = image_base_ff;
      if (write_en) begin
         unique case (reg_index)
            wbss_pkg::REG_PATTERN_0:   pattern_in[0] = pwdata;
            wbss_pkg::REG_PATTERN_1:   pattern_in[1] = pwdata;
            wbss_pkg::REG_PATTERN_2:   pattern_in[2] = pwdata;
            wbss_pkg::REG_PATTERN_3:   pattern_in[3] = pwdata;
            wbss_pkg::REG_PATTERN_LEN: pattern_length_in = pwdata[5:0];
            wbss_pkg::REG_OFFSET:      extra_offset_in = pwdata[31:0];
            wbss_pkg::REG_RELATIVE:    relative_mode_in = pwdata[0];
            wbss_pkg::REG_BASE:        image_base_in = pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            pattern_ff[k] <= '0;
         end
         pattern_length_ff <= wbss_pkg::PATTERN_LEN_RESET;
         extra_offset_ff   <= '0;
         relative_mode_ff  <= 1'b0;
         image_base_ff     <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            pattern_ff[k] <= pattern_in[k];
         end
         pattern_length_ff <= pattern_length_in;
         extra_offset_ff   <= extra_offset_in;
         relative_mode_ff  <= relative_mode_in;
         image_base_ff     <= image_base_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_index)
         wbss_pkg::REG_PATTERN_0:   prdata = pattern_ff[0];
         wbss_pkg::REG_PATTERN_1:   prdata = pattern_ff[1];
         wbss_pkg::REG_PATTERN_2:   prdata = pattern_ff[2];
         wbss_pkg::REG_PATTERN_3:   prdata = pattern_ff[3];
         wbss_pkg::REG_PATTERN_LEN: prdata = {58'd0, pattern_length_ff};
         wbss_pkg::REG_OFFSET:      prdata = {32'd0, extra_offset_ff};
         wbss_pkg::REG_RELATIVE:    prdata = {63'd0, relative_mode_ff};
         wbss_pkg::REG_BASE:        prdata = {32'd0, image_base_ff};
         default:                   prdata = '0;
      endcase
   end

   assign cfg.pattern        = {pattern_ff[3], pattern_ff[2], pattern_ff[1], pattern_ff[0]};
   assign cfg.pattern_length = pattern_length_ff;
   assign cfg.extra_offset   = extra_offset_ff;
   assign cfg.relative_mode  = relative_mode_ff;
   assign cfg.image_base     = image_base_ff;

endmodule

// ----- src/wbss_result.sv -----
// Result pipe of the signature scanner: a holding stage and the output register.
// The holding stage keeps the matched word; the output stage adds the offset, less the base in relative mode.
// Depends on wbss_pkg.
module wbss_result (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wbss_pkg::result_type push_result,
   input  wbss_pkg::cfg_type    cfg,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [31:0]          rsp_value
);

   logic        hold_valid_ff, hold_valid_in;
   logic        hold_found_ff;
   logic [31:0] hold_word_ff;
   logic [31:0] adj_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff;
   logic [31:0] rsp_value_ff;
   logic        hold_move;

   // The holding stage drains whenever the output register is free or being taken.
   assign hold_move = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign full      = hold_valid_ff && !hold_move;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (push) begin
         hold_valid_in = 1'b1;
      end else if (hold_move) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (hold_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload. The adjustment folds the offset and the optional base into one term.
   always_ff @(posedge clock) begin
      adj_ff <= cfg.extra_offset - (cfg.relative_mode ? cfg.image_base : 32'd0);
      if (push) begin
         hold_found_ff <= push_result.found;
         hold_word_ff  <= push_result.word;
      end
      if (hold_move) begin
         rsp_found_ff <= hold_found_ff;
         rsp_value_ff <= hold_found_ff ? (hold_word_ff + adj_ff) : 32'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_value = rsp_value_ff;

   // A miss always reports a zero value.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_value_ff == 32'd0)
      else $error("miss result with nonzero value");

   // A new item is never pushed into a holding stage that cannot drain.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result pushed over a held item");

endmodule
